// ===== rtl/vna_pkg.sv =====
// ----------------------------------------------------------------------------
// vna_pkg: shared definitions for the vertex normal accumulator
// Operation codes, queue entry kinds, the queue control struct and the
// saturating accumulator add.
// ----------------------------------------------------------------------------
`default_nettype none

package vna_pkg;

   localparam int IDX_BITS    = 11;
   localparam int OP_BITS     = 2;
   localparam int NORM_BITS   = 16;
   localparam int SUM_BITS    = 64;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [OP_BITS-1:0] OP_LOAD = 2'd0;
   localparam logic [OP_BITS-1:0] OP_FACE = 2'd1;
   localparam logic [OP_BITS-1:0] OP_READ = 2'd2;

   localparam logic [1:0] KIND_LOAD = 2'd0;
   localparam logic [1:0] KIND_FACE = 2'd1;
   localparam logic [1:0] KIND_READ = 2'd2;

   typedef logic signed [SUM_BITS-1:0] sum_type;

   localparam sum_type SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
   localparam sum_type SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

   // Head of the command queue as seen by the execution side.
   typedef struct packed {
      logic       valid;
      logic [1:0] kind;
      logic       bad;
   } entry_ctl_type;

   function automatic sum_type add_sat(input sum_type a, input sum_type b);
      logic signed [SUM_BITS:0] s;
      s = {a[SUM_BITS-1], a} + {b[SUM_BITS-1], b};
      if (s[SUM_BITS] != s[SUM_BITS-1]) begin
         return s[SUM_BITS] ? SUM_MIN : SUM_MAX;
      end
      return s[SUM_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/vna_front.sv =====
// ----------------------------------------------------------------------------
// vna_front: request intake
// Accepts requests, checks vertex indexes, drops requests that do nothing and
// queues the rest for the execution side.
// ----------------------------------------------------------------------------
`default_nettype none

module vna_front #(
   parameter int VERTEX_SLOTS = 1024,
   parameter int COORD_BITS   = 24
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output      logic                                  req_stall,
   input  wire logic [vna_pkg::OP_BITS-1:0]           req_operation,
   input  wire logic [vna_pkg::IDX_BITS-1:0]          req_vertex_index,
   input  wire logic signed [COORD_BITS-1:0]          req_pos_x,
   input  wire logic signed [COORD_BITS-1:0]          req_pos_y,
   input  wire logic signed [COORD_BITS-1:0]          req_pos_z,
   input  wire logic [vna_pkg::IDX_BITS-1:0]          req_corner_a,
   input  wire logic [vna_pkg::IDX_BITS-1:0]          req_corner_b,
   input  wire logic [vna_pkg::IDX_BITS-1:0]          req_corner_c,
   input  wire logic                                  hold,
   input  wire logic                                  pop,
   output      vna_pkg::entry_ctl_type                head_ctl,
   output      logic [$clog2(VERTEX_SLOTS)-1:0]       head_slot_a,
   output      logic [$clog2(VERTEX_SLOTS)-1:0]       head_slot_b,
   output      logic [$clog2(VERTEX_SLOTS)-1:0]       head_slot_c,
   output      logic [3*COORD_BITS-1:0]               head_pos
);

   localparam int SLOT_BITS = $clog2(VERTEX_SLOTS);
   localparam int PTR_BITS  = $clog2(vna_pkg::QUEUE_DEPTH);
   localparam int CNT_BITS  = $clog2(vna_pkg::QUEUE_DEPTH + 1);

   function automatic logic slot_ok(input logic [vna_pkg::IDX_BITS-1:0] idx);
      return (idx != '0) && (32'(idx) <= 32'(VERTEX_SLOTS));
   endfunction

   logic [1:0]               kind_q_ff  [vna_pkg::QUEUE_DEPTH];
   logic                     bad_q_ff   [vna_pkg::QUEUE_DEPTH];
   logic [SLOT_BITS-1:0]     slot_a_q_ff[vna_pkg::QUEUE_DEPTH];
   logic [SLOT_BITS-1:0]     slot_b_q_ff[vna_pkg::QUEUE_DEPTH];
   logic [SLOT_BITS-1:0]     slot_c_q_ff[vna_pkg::QUEUE_DEPTH];
   logic [3*COORD_BITS-1:0]  pos_q_ff   [vna_pkg::QUEUE_DEPTH];

   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   logic       accept;
   logic       keep;
   logic [1:0] kind;
   logic       bad;
   logic       push;

   assign req_stall = hold || (count_ff == CNT_BITS'(vna_pkg::QUEUE_DEPTH));
   assign accept    = req_valid && !req_stall;

   // A load or face with an index out of range and an unknown operation leave
   // no trace; a read out of range still owes a degenerate result.
   always_comb begin
      keep = 1'b0;
      kind = vna_pkg::KIND_LOAD;
      bad  = 1'b0;
      unique case (req_operation)
         vna_pkg::OP_LOAD: begin
            keep = slot_ok(req_vertex_index);
            kind = vna_pkg::KIND_LOAD;
         end
         vna_pkg::OP_FACE: begin
            keep = slot_ok(req_corner_a) && slot_ok(req_corner_b)
                   && slot_ok(req_corner_c);
            kind = vna_pkg::KIND_FACE;
         end
         vna_pkg::OP_READ: begin
            keep = 1'b1;
            kind = vna_pkg::KIND_READ;
            bad  = !slot_ok(req_vertex_index);
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign push      = accept && keep;
   assign wr_ptr_in = push ? wr_ptr_ff + PTR_BITS'(1) : wr_ptr_ff;
   assign rd_ptr_in = pop ? rd_ptr_ff + PTR_BITS'(1) : rd_ptr_ff;
   assign count_in  = count_ff + CNT_BITS'(push) - CNT_BITS'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         kind_q_ff[wr_ptr_ff] <= kind;
         bad_q_ff[wr_ptr_ff]  <= bad;
         if (kind == vna_pkg::KIND_FACE) begin
            slot_a_q_ff[wr_ptr_ff] <= SLOT_BITS'(req_corner_a - 11'd1);
         end else begin
            slot_a_q_ff[wr_ptr_ff] <= SLOT_BITS'(req_vertex_index - 11'd1);
         end
         slot_b_q_ff[wr_ptr_ff] <= SLOT_BITS'(req_corner_b - 11'd1);
         slot_c_q_ff[wr_ptr_ff] <= SLOT_BITS'(req_corner_c - 11'd1);
         pos_q_ff[wr_ptr_ff]    <= {req_pos_z, req_pos_y, req_pos_x};
      end
   end

   assign head_ctl.valid = (count_ff != '0);
   assign head_ctl.kind  = kind_q_ff[rd_ptr_ff];
   assign head_ctl.bad   = bad_q_ff[rd_ptr_ff];
   assign head_slot_a    = slot_a_q_ff[rd_ptr_ff];
   assign head_slot_b    = slot_b_q_ff[rd_ptr_ff];
   assign head_slot_c    = slot_c_q_ff[rd_ptr_ff];
   assign head_pos       = pos_q_ff[rd_ptr_ff];

endmodule

`default_nettype wire

// ===== rtl/vna_norm.sv =====
// ----------------------------------------------------------------------------
// vna_norm: normal vector normalizer
// Scales an accumulated normal to unit length in Q1.14 with a one-bit-a-cycle
// range shift, a bit-serial square root and a bit-serial divider.
// ----------------------------------------------------------------------------
`default_nettype none

module vna_norm (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   input  wire vna_pkg::sum_type                   sum_x,
   input  wire vna_pkg::sum_type                   sum_y,
   input  wire vna_pkg::sum_type                   sum_z,
   input  wire logic                               take,
   output      logic                               res_valid,
   output      logic [vna_pkg::NORM_BITS-1:0]      norm_x,
   output      logic [vna_pkg::NORM_BITS-1:0]      norm_y,
   output      logic [vna_pkg::NORM_BITS-1:0]      norm_z,
   output      logic                               degenerate
);

   localparam logic [2:0] N_IDLE     = 3'd0;
   localparam logic [2:0] N_SHIFT    = 3'd1;
   localparam logic [2:0] N_SQUARE   = 3'd2;
   localparam logic [2:0] N_SUM      = 3'd3;
   localparam logic [2:0] N_SQRT     = 3'd4;
   localparam logic [2:0] N_DIV_SET  = 3'd5;
   localparam logic [2:0] N_DIV_STEP = 3'd6;
   localparam logic [2:0] N_DONE     = 3'd7;

   localparam int MB       = vna_pkg::SUM_BITS;
   localparam int Q_BITS   = 15;
   localparam int NUM_BITS = 45;
   localparam logic [Q_BITS-1:0] UNIT_Q14 = 15'd16384;

   logic [2:0] state_ff, state_in;

   logic [MB-1:0]  mag_ff [3];
   logic [2:0]     neg_ff;
   logic [MB-1:0]  m_ff;
   logic [59:0]    sq_ff  [3];
   logic [MB-1:0]  x_ff;
   logic [MB-1:0]  root_ff;
   logic [MB-1:0]  bit_ff;
   logic [4:0]     step_ff;
   logic [1:0]     comp_ff;
   logic [32:0]    rem_ff;
   logic [Q_BITS-1:0] low_ff;
   logic [Q_BITS-1:0] q_ff;
   logic [3:0]     cnt_ff;
   logic [vna_pkg::NORM_BITS-1:0] out_ff [3];
   logic           degen_ff;

   logic [MB-1:0]  mag_in [3];
   logic [MB-1:0]  max_in;
   logic [MB-1:0]  trial;
   logic [31:0]    root;
   logic [NUM_BITS-1:0] num;
   logic [32:0]    shifted;
   logic           qbit;
   logic [Q_BITS-1:0] q_in;
   logic [Q_BITS-1:0] q_clamp;
   logic [vna_pkg::NORM_BITS-1:0] signed_q;

   always_comb begin
      mag_in[0] = sum_x[MB-1] ? MB'(0) - MB'(sum_x) : MB'(sum_x);
      mag_in[1] = sum_y[MB-1] ? MB'(0) - MB'(sum_y) : MB'(sum_y);
      mag_in[2] = sum_z[MB-1] ? MB'(0) - MB'(sum_z) : MB'(sum_z);
      max_in    = mag_in[0];
      if (mag_in[1] > max_in) begin
         max_in = mag_in[1];
      end
      if (mag_in[2] > max_in) begin
         max_in = mag_in[2];
      end
   end

   assign trial   = root_ff + bit_ff;
   assign root    = root_ff[31:0];
   assign num     = {1'b0, mag_ff[comp_ff][29:0], 14'd0} + NUM_BITS'(root[31:1]);
   assign shifted = {rem_ff[31:0], low_ff[Q_BITS-1]};
   assign qbit    = (shifted >= {1'b0, root});
   assign q_in    = {q_ff[Q_BITS-2:0], qbit};
   assign q_clamp = (q_in > UNIT_Q14) ? UNIT_Q14 : q_in;
   assign signed_q = neg_ff[comp_ff] ? vna_pkg::NORM_BITS'(0) - {1'b0, q_clamp}
                                     : {1'b0, q_clamp};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         N_IDLE: begin
            if (start) begin
               state_in = (max_in == '0) ? N_DONE : N_SHIFT;
            end
         end
         N_SHIFT: begin
            if ((m_ff[MB-1:30] == '0) && m_ff[29]) begin
               state_in = N_SQUARE;
            end
         end
         N_SQUARE:   state_in = N_SUM;
         N_SUM:      state_in = N_SQRT;
         N_SQRT: begin
            if (step_ff == 5'd31) begin
               state_in = N_DIV_SET;
            end
         end
         N_DIV_SET:  state_in = N_DIV_STEP;
         N_DIV_STEP: begin
            if (cnt_ff == 4'(Q_BITS - 1)) begin
               state_in = (comp_ff == 2'd2) ? N_DONE : N_DIV_SET;
            end
         end
         N_DONE: begin
            if (take) begin
               state_in = N_IDLE;
            end
         end
         default:    state_in = N_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= N_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         N_IDLE: begin
            for (int k = 0; k < 3; k++) begin
               mag_ff[k] <= mag_in[k];
               out_ff[k] <= '0;
            end
            neg_ff   <= {sum_z[MB-1], sum_y[MB-1], sum_x[MB-1]};
            m_ff     <= max_in;
            degen_ff <= (max_in == '0);
         end
         N_SHIFT: begin
            // Bring the largest magnitude into [2^29, 2^30); right shifts truncate.
            if (m_ff[MB-1:30] != '0) begin
               m_ff <= m_ff >> 1;
               for (int k = 0; k < 3; k++) begin
                  mag_ff[k] <= mag_ff[k] >> 1;
               end
            end else if (!m_ff[29]) begin
               m_ff <= m_ff << 1;
               for (int k = 0; k < 3; k++) begin
                  mag_ff[k] <= mag_ff[k] << 1;
               end
            end
         end
         N_SQUARE: begin
            for (int k = 0; k < 3; k++) begin
               sq_ff[k] <= mag_ff[k][29:0] * mag_ff[k][29:0];
            end
         end
         N_SUM: begin
            x_ff    <= MB'(sq_ff[0]) + MB'(sq_ff[1]) + MB'(sq_ff[2]);
            root_ff <= '0;
            bit_ff  <= MB'(1) << 62;
            step_ff <= '0;
            comp_ff <= '0;
         end
         N_SQRT: begin
            if (x_ff >= trial) begin
               x_ff    <= x_ff - trial;
               root_ff <= (root_ff >> 1) + bit_ff;
            end else begin
               root_ff <= root_ff >> 1;
            end
            bit_ff  <= bit_ff >> 2;
            step_ff <= step_ff + 5'd1;
         end
         N_DIV_SET: begin
            // The quotient fits 15 bits, so the upper numerator bits start below r.
            rem_ff <= 33'(num[NUM_BITS-1:Q_BITS]);
            low_ff <= num[Q_BITS-1:0];
            q_ff   <= '0;
            cnt_ff <= '0;
         end
         N_DIV_STEP: begin
            rem_ff <= qbit ? shifted - {1'b0, root} : shifted;
            low_ff <= low_ff << 1;
            q_ff   <= q_in;
            cnt_ff <= cnt_ff + 4'd1;
            if (cnt_ff == 4'(Q_BITS - 1)) begin
               out_ff[comp_ff] <= signed_q;
               comp_ff         <= comp_ff + 2'd1;
            end
         end
         N_DONE: begin
         end
         default: begin
         end
      endcase
   end

   assign res_valid  = (state_ff == N_DONE);
   assign norm_x     = out_ff[0];
   assign norm_y     = out_ff[1];
   assign norm_z     = out_ff[2];
   assign degenerate = degen_ff;

endmodule

`default_nettype wire

// ===== rtl/vna_back.sv =====
// ----------------------------------------------------------------------------
// vna_back: command execution
// Holds the position and accumulator memories, clears the accumulators after
// reset, runs loads and faces, drives reads through the normalizer and keeps
// the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module vna_back #(
   parameter int VERTEX_SLOTS = 1024,
   parameter int COORD_BITS   = 24
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire vna_pkg::entry_ctl_type                head_ctl,
   input  wire logic [$clog2(VERTEX_SLOTS)-1:0]       head_slot_a,
   input  wire logic [$clog2(VERTEX_SLOTS)-1:0]       head_slot_b,
   input  wire logic [$clog2(VERTEX_SLOTS)-1:0]       head_slot_c,
   input  wire logic [3*COORD_BITS-1:0]               head_pos,
   output      logic                                  pop,
   output      logic                                  clearing,
   output      logic                                  rsp_valid,
   input  wire logic                                  rsp_stall,
   output      logic signed [vna_pkg::NORM_BITS-1:0]  rsp_norm_x,
   output      logic signed [vna_pkg::NORM_BITS-1:0]  rsp_norm_y,
   output      logic signed [vna_pkg::NORM_BITS-1:0]  rsp_norm_z,
   output      logic                                  rsp_degenerate
);

   localparam int SLOT_BITS = $clog2(VERTEX_SLOTS);
   localparam int CB        = COORD_BITS;
   localparam int EB        = CB + 1;
   localparam int PB        = 2 * EB;
   localparam int NB        = PB + 1;
   localparam int SB        = vna_pkg::SUM_BITS;

   localparam logic [3:0] ST_CLEAR   = 4'd0;
   localparam logic [3:0] ST_IDLE    = 4'd1;
   localparam logic [3:0] ST_POS_A   = 4'd2;
   localparam logic [3:0] ST_POS_B   = 4'd3;
   localparam logic [3:0] ST_POS_C   = 4'd4;
   localparam logic [3:0] ST_EDGE    = 4'd5;
   localparam logic [3:0] ST_MUL     = 4'd6;
   localparam logic [3:0] ST_CROSS   = 4'd7;
   localparam logic [3:0] ST_ACC_RD  = 4'd8;
   localparam logic [3:0] ST_ACC_WR  = 4'd9;
   localparam logic [3:0] ST_RD_SUM  = 4'd10;
   localparam logic [3:0] ST_RD_DATA = 4'd11;
   localparam logic [3:0] ST_RD_WAIT = 4'd12;

   logic [3:0] state_ff, state_in;

   logic [3*CB-1:0] pos_mem [VERTEX_SLOTS];
   logic [3*SB-1:0] sum_mem [VERTEX_SLOTS];

   logic [SLOT_BITS-1:0] clr_cnt_ff;
   logic [SLOT_BITS-1:0] slot_a_ff, slot_b_ff, slot_c_ff;
   logic [1:0]           corner_ff;
   logic [3*CB-1:0]      pos_rd_ff, pa_ff, pb_ff;
   logic [3*SB-1:0]      sum_rd_ff;
   logic signed [EB-1:0] e1_ff [3];
   logic signed [EB-1:0] e2_ff [3];
   logic signed [PB-1:0] prod_ff [6];
   vna_pkg::sum_type     n_ff [3];

   logic                 rsp_valid_ff;
   logic [vna_pkg::NORM_BITS-1:0] rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic                 rsp_degen_ff;

   logic [SLOT_BITS-1:0] corner_addr;
   logic [SLOT_BITS-1:0] pos_rd_addr;
   logic [SLOT_BITS-1:0] sum_rd_addr;
   logic                 pos_we;
   logic                 sum_we;
   logic [SLOT_BITS-1:0] sum_wr_addr;
   logic [3*SB-1:0]      sum_wr_data;
   logic                 take_load, take_face, take_read;
   logic                 norm_start;
   vna_pkg::sum_type     norm_sx, norm_sy, norm_sz;
   logic                 norm_take;
   logic                 norm_valid;
   logic [vna_pkg::NORM_BITS-1:0] norm_x, norm_y, norm_z;
   logic                 norm_degen;
   logic                 out_free;

   assign clearing  = (state_ff == ST_CLEAR);
   assign pop       = (state_ff == ST_IDLE) && head_ctl.valid;
   assign take_load = pop && (head_ctl.kind == vna_pkg::KIND_LOAD);
   assign take_face = pop && (head_ctl.kind == vna_pkg::KIND_FACE);
   assign take_read = pop && (head_ctl.kind == vna_pkg::KIND_READ);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      unique case (corner_ff)
         2'd0:    corner_addr = slot_a_ff;
         2'd1:    corner_addr = slot_b_ff;
         default: corner_addr = slot_c_ff;
      endcase
   end

   always_comb begin
      unique case (state_ff)
         ST_POS_A: pos_rd_addr = slot_a_ff;
         ST_POS_B: pos_rd_addr = slot_b_ff;
         default:  pos_rd_addr = slot_c_ff;
      endcase
   end

   assign sum_rd_addr = (state_ff == ST_RD_SUM) ? slot_a_ff : corner_addr;
   assign pos_we      = take_load;

   always_comb begin
      sum_we      = 1'b0;
      sum_wr_addr = corner_addr;
      sum_wr_data = '0;
      if (state_ff == ST_CLEAR) begin
         sum_we      = 1'b1;
         sum_wr_addr = clr_cnt_ff;
      end else if (take_load) begin
         sum_we      = 1'b1;
         sum_wr_addr = head_slot_a;
      end else if (state_ff == ST_ACC_WR) begin
         sum_we      = 1'b1;
         sum_wr_data = {vna_pkg::add_sat(sum_rd_ff[3*SB-1:2*SB], n_ff[2]),
                        vna_pkg::add_sat(sum_rd_ff[2*SB-1:SB], n_ff[1]),
                        vna_pkg::add_sat(sum_rd_ff[SB-1:0], n_ff[0])};
      end
   end

   // A read of an out-of-range slot goes through the normalizer as a zero
   // vector, which comes back degenerate.
   assign norm_start = (take_read && head_ctl.bad) || (state_ff == ST_RD_DATA);
   assign norm_sx    = (state_ff == ST_RD_DATA) ? sum_rd_ff[SB-1:0] : '0;
   assign norm_sy    = (state_ff == ST_RD_DATA) ? sum_rd_ff[2*SB-1:SB] : '0;
   assign norm_sz    = (state_ff == ST_RD_DATA) ? sum_rd_ff[3*SB-1:2*SB] : '0;
   assign norm_take  = (state_ff == ST_RD_WAIT) && norm_valid && out_free;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_cnt_ff == SLOT_BITS'(VERTEX_SLOTS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (take_face) begin
               state_in = ST_POS_A;
            end else if (take_read) begin
               state_in = head_ctl.bad ? ST_RD_WAIT : ST_RD_SUM;
            end
         end
         ST_POS_A:   state_in = ST_POS_B;
         ST_POS_B:   state_in = ST_POS_C;
         ST_POS_C:   state_in = ST_EDGE;
         ST_EDGE:    state_in = ST_MUL;
         ST_MUL:     state_in = ST_CROSS;
         ST_CROSS:   state_in = ST_ACC_RD;
         ST_ACC_RD:  state_in = ST_ACC_WR;
         ST_ACC_WR:  state_in = (corner_ff == 2'd2) ? ST_IDLE : ST_ACC_RD;
         ST_RD_SUM:  state_in = ST_RD_DATA;
         ST_RD_DATA: state_in = ST_RD_WAIT;
         ST_RD_WAIT: begin
            if (norm_take) begin
               state_in = ST_IDLE;
            end
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_cnt_ff <= clr_cnt_ff + SLOT_BITS'(1);
         end
         if (norm_take) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (norm_take) begin
         rsp_x_ff     <= norm_x;
         rsp_y_ff     <= norm_y;
         rsp_z_ff     <= norm_z;
         rsp_degen_ff <= norm_degen;
      end
   end

   always_ff @(posedge clock) begin
      if (pos_we) begin
         pos_mem[head_slot_a] <= head_pos;
      end
      pos_rd_ff <= pos_mem[pos_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (sum_we) begin
         sum_mem[sum_wr_addr] <= sum_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      sum_rd_ff <= sum_mem[sum_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         slot_a_ff <= head_slot_a;
         slot_b_ff <= head_slot_b;
         slot_c_ff <= head_slot_c;
      end
      if (state_ff == ST_CROSS) begin
         corner_ff <= 2'd0;
      end else if (state_ff == ST_ACC_WR) begin
         corner_ff <= corner_ff + 2'd1;
      end
      if (state_ff == ST_POS_B) begin
         pa_ff <= pos_rd_ff;
      end
      if (state_ff == ST_POS_C) begin
         pb_ff <= pos_rd_ff;
      end
      if (state_ff == ST_EDGE) begin
         for (int k = 0; k < 3; k++) begin
            e1_ff[k] <= EB'($signed(pb_ff[k*CB +: CB])) - EB'($signed(pa_ff[k*CB +: CB]));
            e2_ff[k] <= EB'($signed(pos_rd_ff[k*CB +: CB]))
                        - EB'($signed(pa_ff[k*CB +: CB]));
         end
      end
      if (state_ff == ST_MUL) begin
         prod_ff[0] <= e1_ff[1] * e2_ff[2];
         prod_ff[1] <= e1_ff[2] * e2_ff[1];
         prod_ff[2] <= e1_ff[2] * e2_ff[0];
         prod_ff[3] <= e1_ff[0] * e2_ff[2];
         prod_ff[4] <= e1_ff[0] * e2_ff[1];
         prod_ff[5] <= e1_ff[1] * e2_ff[0];
      end
      if (state_ff == ST_CROSS) begin
         for (int k = 0; k < 3; k++) begin
            n_ff[k] <= SB'(NB'(prod_ff[2*k]) - NB'(prod_ff[2*k+1]));
         end
      end
   end

   vna_norm u_norm (
      .clock      (clock),
      .reset      (reset),
      .start      (norm_start),
      .sum_x      (norm_sx),
      .sum_y      (norm_sy),
      .sum_z      (norm_sz),
      .take       (norm_take),
      .res_valid  (norm_valid),
      .norm_x     (norm_x),
      .norm_y     (norm_y),
      .norm_z     (norm_z),
      .degenerate (norm_degen)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_norm_x     = rsp_x_ff;
   assign rsp_norm_y     = rsp_y_ff;
   assign rsp_norm_z     = rsp_z_ff;
   assign rsp_degenerate = rsp_degen_ff;

endmodule

`default_nettype wire

// ===== rtl/vertex_normal_accumulator.sv =====
// ----------------------------------------------------------------------------
// vertex_normal_accumulator: area-weighted smooth vertex normals
// Loads vertex positions, accumulates face cross products into per-vertex
// sums and returns normalized Q1.14 normals on request.
//
// After reset the block clears all VERTEX_SLOTS accumulators, one per cycle,
// and holds req_stall high while it does so. Requests then enter a two-entry
// queue, so intake continues while the execution side works or a result waits
// on rsp_stall. A face runs three position reads, edge, multiply and
// cross-product stages, then a read and write of each corner's accumulator;
// a read of a nonzero sum runs the one-bit-per-cycle range shift, the 32-step
// square root and the bit-serial divide done once per component. The finished
// result then sits in the output register until it is taken. Loads and faces
// with an out-of-range index and operation 3 are dropped; a read out of range
// or of a zero sum returns a zero vector with rsp_degenerate set.
// ----------------------------------------------------------------------------
`default_nettype none

module vertex_normal_accumulator #(
   parameter int VERTEX_SLOTS = 1024,
   parameter int COORD_BITS   = 24
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output      logic                                  req_stall,
   input  wire logic [vna_pkg::OP_BITS-1:0]           req_operation,
   input  wire logic [vna_pkg::IDX_BITS-1:0]          req_vertex_index,
   input  wire logic signed [COORD_BITS-1:0]          req_pos_x,
   input  wire logic signed [COORD_BITS-1:0]          req_pos_y,
   input  wire logic signed [COORD_BITS-1:0]          req_pos_z,
   input  wire logic [vna_pkg::IDX_BITS-1:0]          req_corner_a,
   input  wire logic [vna_pkg::IDX_BITS-1:0]          req_corner_b,
   input  wire logic [vna_pkg::IDX_BITS-1:0]          req_corner_c,
   output      logic                                  rsp_valid,
   input  wire logic                                  rsp_stall,
   output      logic signed [vna_pkg::NORM_BITS-1:0]  rsp_norm_x,
   output      logic signed [vna_pkg::NORM_BITS-1:0]  rsp_norm_y,
   output      logic signed [vna_pkg::NORM_BITS-1:0]  rsp_norm_z,
   output      logic                                  rsp_degenerate
);

   localparam int SLOT_BITS = $clog2(VERTEX_SLOTS);

   vna_pkg::entry_ctl_type head_ctl;
   logic [SLOT_BITS-1:0]   head_slot_a, head_slot_b, head_slot_c;
   logic [3*COORD_BITS-1:0] head_pos;
   logic                   pop;
   logic                   clearing;

   vna_front #(
      .VERTEX_SLOTS (VERTEX_SLOTS),
      .COORD_BITS   (COORD_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_vertex_index (req_vertex_index),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_pos_z        (req_pos_z),
      .req_corner_a     (req_corner_a),
      .req_corner_b     (req_corner_b),
      .req_corner_c     (req_corner_c),
      .hold             (clearing),
      .pop              (pop),
      .head_ctl         (head_ctl),
      .head_slot_a      (head_slot_a),
      .head_slot_b      (head_slot_b),
      .head_slot_c      (head_slot_c),
      .head_pos         (head_pos)
   );

   vna_back #(
      .VERTEX_SLOTS (VERTEX_SLOTS),
      .COORD_BITS   (COORD_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .head_ctl       (head_ctl),
      .head_slot_a    (head_slot_a),
      .head_slot_b    (head_slot_b),
      .head_slot_c    (head_slot_c),
      .head_pos       (head_pos),
      .pop            (pop),
      .clearing       (clearing),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_norm_x     (rsp_norm_x),
      .rsp_norm_y     (rsp_norm_y),
      .rsp_norm_z     (rsp_norm_z),
      .rsp_degenerate (rsp_degenerate)
   );

endmodule

`default_nettype wire

// ===== rtl/vna_checker.sv =====
// ----------------------------------------------------------------------------
// vna_checker: port-level checks for the vertex normal accumulator
// Watches the result channel for reset behavior, held transfers and the
// shape of returned normals.
// ----------------------------------------------------------------------------
`default_nettype none

module vna_checker (
   input wire logic                                  clock,
   input wire logic                                  reset,
   input wire logic                                  rsp_valid,
   input wire logic                                  rsp_stall,
   input wire logic signed [vna_pkg::NORM_BITS-1:0]  rsp_norm_x,
   input wire logic signed [vna_pkg::NORM_BITS-1:0]  rsp_norm_y,
   input wire logic signed [vna_pkg::NORM_BITS-1:0]  rsp_norm_z,
   input wire logic                                  rsp_degenerate
);

   // No result may be pending right after reset.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled result stays in place.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_norm_x)
         && $stable(rsp_norm_y) && $stable(rsp_norm_z) && $stable(rsp_degenerate))
      else $error("stalled result changed");

   // A degenerate result is the zero vector.
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |->
         rsp_norm_x == '0 && rsp_norm_y == '0 && rsp_norm_z == '0)
      else $error("degenerate result with nonzero vector");

   // A unit normal has components within one and at least one nonzero.
   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_degenerate |->
         rsp_norm_x >= -16'sd16384 && rsp_norm_x <= 16'sd16384
         && rsp_norm_y >= -16'sd16384 && rsp_norm_y <= 16'sd16384
         && rsp_norm_z >= -16'sd16384 && rsp_norm_z <= 16'sd16384
         && (rsp_norm_x != '0 || rsp_norm_y != '0 || rsp_norm_z != '0))
      else $error("normal component out of range");

endmodule

bind vertex_normal_accumulator vna_checker u_vna_checker (.*);

`default_nettype wire

// ===== sim/vertex_normal_accumulator_tb.sv =====
// ----------------------------------------------------------------------------
// vertex_normal_accumulator_tb: self-checking bench for the normal accumulator
// Loads small random meshes, accumulates faces and reads back the unit
// normals, predicting every returned normal in the bench and comparing field by
// field. Both handshakes idle at random; the receiver also holds off once for a
// long stretch, and the sender drains now and then.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module vertex_normal_accumulator_tb;

   localparam int SLOTS = 1024;
   localparam logic [vna_pkg::OP_BITS-1:0] OP_NONE = 2'd3;
   localparam int IDLE_LIMIT = 6000;
   localparam int HOLD_CYCLES = 500;

   typedef struct {
      logic [1:0]         op;
      logic [10:0]        vidx;
      logic signed [23:0] px, py, pz;
      logic [10:0]        ca, cb, cc;
      bit                 pause;
   } mesh_cmd_type;

   typedef struct {
      logic signed [15:0] nx, ny, nz;
      logic               degen;
   } normal_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_operation = '0;
   logic [10:0] req_vertex_index = '0;
   logic signed [23:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic [10:0] req_corner_a = '0, req_corner_b = '0, req_corner_c = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [15:0] rsp_norm_x, rsp_norm_y, rsp_norm_z;
   logic rsp_degenerate;

   vertex_normal_accumulator u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_operation(req_operation), .req_vertex_index(req_vertex_index),
      .req_pos_x(req_pos_x), .req_pos_y(req_pos_y), .req_pos_z(req_pos_z),
      .req_corner_a(req_corner_a), .req_corner_b(req_corner_b),
      .req_corner_c(req_corner_c),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_norm_x(rsp_norm_x), .rsp_norm_y(rsp_norm_y), .rsp_norm_z(rsp_norm_z),
      .rsp_degenerate(rsp_degenerate)
   );

   mesh_cmd_type pending_q[$];
   mesh_cmd_type cur_cmd;
   normal_type   normal_q[$];

   logic signed [23:0] pos_x_mem[SLOTS], pos_y_mem[SLOTS], pos_z_mem[SLOTS];
   longint sum_x_mem[SLOTS], sum_y_mem[SLOTS], sum_z_mem[SLOTS];

   int errors = 0;
   int req_count = 0;
   int idle_count = 0;
   int send_gap = 0, recv_gap = 0, hold_left = 0;
   bit hold_done = 1'b0;
   logic req_taken = 1'b0, rsp_taken = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------- predictor ----------------
   function automatic longint sat_add(longint a, longint b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) begin
         return s[64] ? longint'(vna_pkg::SUM_MIN) : longint'(vna_pkg::SUM_MAX);
      end
      return s[63:0];
   endfunction

   function automatic bit in_range(logic [10:0] v);
      return v >= 1 && v <= SLOTS;
   endfunction

   task automatic accumulate_face(logic [10:0] ia, logic [10:0] ib, logic [10:0] ic);
      int a, b, c;
      longint e1x, e1y, e1z, e2x, e2y, e2z, nx, ny, nz;
      if (!in_range(ia) || !in_range(ib) || !in_range(ic)) return;
      a = int'(ia) - 1; b = int'(ib) - 1; c = int'(ic) - 1;
      e1x = longint'(pos_x_mem[b]) - longint'(pos_x_mem[a]);
      e1y = longint'(pos_y_mem[b]) - longint'(pos_y_mem[a]);
      e1z = longint'(pos_z_mem[b]) - longint'(pos_z_mem[a]);
      e2x = longint'(pos_x_mem[c]) - longint'(pos_x_mem[a]);
      e2y = longint'(pos_y_mem[c]) - longint'(pos_y_mem[a]);
      e2z = longint'(pos_z_mem[c]) - longint'(pos_z_mem[a]);
      nx = e1y * e2z - e1z * e2y;
      ny = e1z * e2x - e1x * e2z;
      nz = e1x * e2y - e1y * e2x;
      foreach (sum_x_mem[i]) begin
         if (i == a || i == b || i == c) begin
            sum_x_mem[i] = sat_add(sum_x_mem[i], nx);
            sum_y_mem[i] = sat_add(sum_y_mem[i], ny);
            sum_z_mem[i] = sat_add(sum_z_mem[i], nz);
         end
      end
   endtask

   function automatic normal_type predict_normal(logic [10:0] vi);
      normal_type o;
      longint s[3];
      longint unsigned mg[3];
      longint unsigned m, len2, r, rem, bitv, q;
      logic signed [15:0] res[3];
      o = '{16'sd0, 16'sd0, 16'sd0, 1'b1};
      if (!in_range(vi)) return o;
      s[0] = sum_x_mem[vi-1]; s[1] = sum_y_mem[vi-1]; s[2] = sum_z_mem[vi-1];
      m = 0;
      for (int k = 0; k < 3; k++) begin
         mg[k] = s[k] < 0 ? longint'(-s[k]) : s[k];
         if (mg[k] > m) m = mg[k];
      end
      if (m == 0) return o;
      while (m >= 64'd1 << 30) begin
         m >>= 1;
         for (int k = 0; k < 3; k++) mg[k] >>= 1;
      end
      while (m < 64'd1 << 29) begin
         m <<= 1;
         for (int k = 0; k < 3; k++) mg[k] <<= 1;
      end
      len2 = mg[0] * mg[0] + mg[1] * mg[1] + mg[2] * mg[2];
      // Bit-serial integer square root, floor.
      r = 0; rem = len2; bitv = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (rem >= r + bitv) begin
            rem = rem - (r + bitv);
            r = (r >> 1) + bitv;
         end else begin
            r = r >> 1;
         end
         bitv = bitv >> 2;
      end
      for (int k = 0; k < 3; k++) begin
         q = (mg[k] * 64'd16384 + (r >> 1)) / r;
         if (q > 16384) q = 16384;
         res[k] = s[k] < 0 ? -16'(q) : 16'(q);
      end
      o = '{res[0], res[1], res[2], 1'b0};
      return o;
   endfunction

   task automatic apply_cmd(mesh_cmd_type c);
      unique case (c.op)
         vna_pkg::OP_LOAD: begin
            if (in_range(c.vidx)) begin
               pos_x_mem[c.vidx-1] = c.px; pos_y_mem[c.vidx-1] = c.py;
               pos_z_mem[c.vidx-1] = c.pz;
               sum_x_mem[c.vidx-1] = 0; sum_y_mem[c.vidx-1] = 0;
               sum_z_mem[c.vidx-1] = 0;
            end
         end
         vna_pkg::OP_FACE: accumulate_face(c.ca, c.cb, c.cc);
         vna_pkg::OP_READ: normal_q.insert(normal_q.size(), predict_normal(c.vidx));
         default: ;
      endcase
   endtask

   // ---------------- stimulus ----------------
   function automatic int draw_gap();
      if (((req_count / 150) % 3) == 1) return 0;
      return $urandom_range(0, 18);
   endfunction

   task automatic queue_cmd(mesh_cmd_type c);
      pending_q.insert(pending_q.size(), c);
   endtask

   function automatic mesh_cmd_type blank_cmd(logic [1:0] op);
      mesh_cmd_type c;
      c.op = op; c.vidx = 11'($urandom);
      c.px = 24'($urandom); c.py = 24'($urandom); c.pz = 24'($urandom);
      c.ca = 11'($urandom); c.cb = 11'($urandom); c.cc = 11'($urandom);
      c.pause = 1'b0;
      return c;
   endfunction

   task automatic push_load(int vi, logic signed [23:0] x, logic signed [23:0] y,
                            logic signed [23:0] z);
      mesh_cmd_type c;
      c = blank_cmd(vna_pkg::OP_LOAD);
      c.vidx = 11'(vi); c.px = x; c.py = y; c.pz = z;
      queue_cmd(c);
   endtask

   task automatic push_face(int a, int b, int c3);
      mesh_cmd_type c;
      c = blank_cmd(vna_pkg::OP_FACE);
      c.ca = 11'(a); c.cb = 11'(b); c.cc = 11'(c3);
      queue_cmd(c);
   endtask

   task automatic push_read(int vi);
      mesh_cmd_type c;
      c = blank_cmd(vna_pkg::OP_READ);
      c.vidx = 11'(vi);
      queue_cmd(c);
   endtask

   task automatic push_pause();
      mesh_cmd_type c;
      c = blank_cmd(OP_NONE);
      c.pause = 1'b1;
      queue_cmd(c);
   endtask

   function automatic logic signed [23:0] rand_coord(bit narrow);
      if (narrow) return $signed(24'($urandom_range(0, 8191))) - 24'sd4096;
      return 24'($urandom);
   endfunction

   function automatic int bad_index();
      return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(SLOTS + 1, 2047);
   endfunction

   task automatic push_mesh();
      int set[6];
      int nv, nf;
      bit narrow;
      nv = $urandom_range(3, 6);
      nf = $urandom_range(2, 8);
      narrow = 1'($urandom_range(0, 1));
      for (int i = 0; i < nv; i++) begin
         set[i] = $urandom_range(1, SLOTS);
         push_load(set[i], rand_coord(narrow), rand_coord(narrow), rand_coord(narrow));
      end
      for (int i = 0; i < nf; i++) begin
         push_face(set[$urandom_range(0, nv-1)], set[$urandom_range(0, nv-1)],
                   set[$urandom_range(0, nv-1)]);
         if ($urandom_range(0, 9) == 0) begin
            push_load(set[$urandom_range(0, nv-1)], rand_coord(narrow),
                      rand_coord(narrow), rand_coord(narrow));
         end
      end
      for (int i = 0; i < nv; i++) begin
         if ($urandom_range(0, 3) != 0) push_read(set[i]);
      end
   endtask

   task automatic push_noise();
      mesh_cmd_type c;
      case ($urandom_range(0, 4))
         0: queue_cmd(blank_cmd(OP_NONE));
         1: push_load(bad_index(), 24'($urandom), 24'($urandom), 24'($urandom));
         2: push_face(bad_index(), $urandom_range(0, 2047), $urandom_range(0, 2047));
         3: push_read($urandom_range(0, 2047));
         default: begin
            c = blank_cmd(vna_pkg::OP_FACE);
            c.cc = 11'(bad_index());
            queue_cmd(c);
         end
      endcase
   endtask

   initial begin
      // Directed: full-scale coordinates, cancelling faces, tiny normals.
      push_load(1, 24'sh7FFFFF, 24'sh800000, 24'sd0);
      push_load(2, 24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF);
      push_load(SLOTS, 24'sd0, 24'sd0, 24'sh800000);
      push_face(1, 2, SLOTS);
      push_read(1);
      push_face(SLOTS, 2, 1);
      push_read(2);
      push_face(1, 1, 2);
      push_face(2, 1, SLOTS);
      push_read(SLOTS);
      push_load(3, 24'sd0, 24'sd0, 24'sd0);
      push_load(4, 24'sd1, 24'sd0, 24'sd0);
      push_load(5, 24'sd0, 24'sd1, 24'sd0);
      push_face(3, 4, 5);
      push_read(3);
      push_read(500);
      push_read(0);
      push_read(2047);
      push_load(0, 24'sd5, 24'sd5, 24'sd5);
      push_load(SLOTS + 1, 24'sd5, 24'sd5, 24'sd5);
      push_face(0, 1, 2);
      push_face(1, 2, SLOTS + 1);
      queue_cmd(blank_cmd(OP_NONE));
      push_read(4);
      push_pause();

      while (pending_q.size() < 800) begin
         if ($urandom_range(0, 4) == 0) push_noise();
         else push_mesh();
         if ($urandom_range(0, 24) == 0) push_pause();
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (pending_q.size() != 0 || req_valid || normal_q.size() != 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

   // ---------------- driver ----------------
   always @(negedge clock) begin
      mesh_cmd_type c;
      logic next_valid;
      if (!reset && !(req_valid && !req_taken)) begin
         next_valid = 1'b0;
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
         end else if (pending_q.size() > 0) begin
            if (pending_q[0].pause) begin
               // Drain: hold back until every predicted normal has come back.
               if (normal_q.size() == 0) void'(pending_q.pop_front());
            end else begin
               c = pending_q.pop_front();
               cur_cmd <= c;
               req_operation <= c.op;
               req_vertex_index <= c.vidx;
               req_pos_x <= c.px; req_pos_y <= c.py; req_pos_z <= c.pz;
               req_corner_a <= c.ca; req_corner_b <= c.cb; req_corner_c <= c.cc;
               next_valid = 1'b1;
               send_gap <= draw_gap();
            end
         end
         req_valid <= next_valid;
      end
   end

   // ---------------- receiver ----------------
   always @(negedge clock) begin
      logic st;
      int g;
      if (!reset) begin
         st = 1'b0;
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            st = 1'b1;
         end else if (!hold_done && req_count >= 400) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            st = 1'b1;
         end else if (rsp_taken) begin
            g = draw_gap();
            recv_gap <= g;
            st = g != 0;
         end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            st = recv_gap > 1;
         end
         rsp_stall <= st;
      end
   end

   // ---------------- monitor ----------------
   task automatic report_mismatch(string field, int got, int want);
      $display("mismatch on %s: got %0d, expected %0d", field, got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      normal_type w;
      req_taken <= req_valid && !req_stall;
      rsp_taken <= rsp_valid && !rsp_stall;
      if (req_valid && !req_stall) begin
         apply_cmd(cur_cmd);
         req_count <= req_count + 1;
      end
      if (rsp_valid && !rsp_stall) begin
         if (normal_q.size() == 0) begin
            report_mismatch("unexpected transfer", 1, 0);
         end else begin
            w = normal_q.pop_front();
            if (rsp_norm_x !== w.nx)
               report_mismatch("norm_x", int'(rsp_norm_x), int'(w.nx));
            if (rsp_norm_y !== w.ny)
               report_mismatch("norm_y", int'(rsp_norm_y), int'(w.ny));
            if (rsp_norm_z !== w.nz)
               report_mismatch("norm_z", int'(rsp_norm_z), int'(w.nz));
            if (rsp_degenerate !== w.degen)
               report_mismatch("degenerate", int'(rsp_degenerate), int'(w.degen));
         end
      end
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_count <= 0;
      else idle_count <= idle_count + 1;
      if (idle_count >= IDLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

endmodule

`default_nettype wire
